// ===== sv/rgbgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgb_pkg: shared types and constants of the grey-scale blur block
// Holds the grey conversion weights, the 7x7 kernel, the divider constants
// and the types that travel between the modules.
// ----------------------------------------------------------------------------
package rgbgb_pkg;

  // Configuration registers.
  localparam int unsigned CFG_W        = 12;
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;
  localparam int unsigned MIN_SIZE     = 7;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Grey conversion: (307 r + 604 g + 113 b) >> 10.
  localparam int unsigned GREY_R  = 307;
  localparam int unsigned GREY_G  = 604;
  localparam int unsigned GREY_B  = 113;
  localparam int unsigned GREY_SH = 10;
  localparam int unsigned GREY_W  = 18;

  // Window geometry.
  localparam int unsigned LINES     = 6;
  localparam int unsigned WIN       = 7;
  localparam int unsigned WIN_LAST  = 6;
  localparam int unsigned BORDER    = 3;
  localparam int unsigned OUT_W     = 11;

  typedef logic [LINES-1:0][7:0]         line_t;
  typedef logic [WIN-1:0][WIN-1:0][7:0]  win_t;

  // Kernel weights in tenths.
  localparam int unsigned WEIGHT [WIN][WIN] = '{
    '{0,  0,   0,   5,   0,  0, 0},
    '{0,  5,  18,  32,  18,  5, 0},
    '{0, 18,  64, 100,  64, 18, 0},
    '{5, 32, 100, 100, 100, 32, 5},
    '{0, 18,  64, 100,  64, 18, 0},
    '{0,  5,  18,  32,  18,  5, 0},
    '{0,  0,   0,   5,   0,  0, 0}
  };

  // Sum widths: one row stays below 2^17, the whole window below 2^19.
  localparam int unsigned ROW_W = 17;
  localparam int unsigned SUM_W = 19;

  // floor(S / 10) as (S * 419431) >> 22, exact for S below 699050.
  localparam int unsigned DIV10_MUL = 419431;
  localparam int unsigned DIV10_SH  = 22;
  localparam int unsigned P10_W     = 38;
  localparam int unsigned Q10_W     = 15;
  // floor(x / 203) as (x * 82647) >> 24, exact for x below 134217.
  localparam int unsigned DIV203_MUL = 82647;
  localparam int unsigned DIV203_SH  = 24;
  localparam int unsigned TWO_M_W    = 16;
  localparam int unsigned P203_W     = 33;
  localparam int unsigned BLUR_MAX   = 255;

  typedef struct packed {
    logic [OUT_W-1:0] out_column;
    logic [OUT_W-1:0] out_row;
    logic             frame_end;
  } meta_t;

endpackage

// ===== sv/rgbgb_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgb_line_store: six grey lines, one word per column
// Each word holds the grey bytes of all six lines at one column. One read
// and one write port; the read data is registered.
// ----------------------------------------------------------------------------
module rgbgb_line_store #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_i,
  output rgbgb_pkg::line_t          rd_data_o,
  input  logic                      wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  rgbgb_pkg::line_t          wr_data_i
);

  rgbgb_pkg::line_t mem [DEPTH];
  rgbgb_pkg::line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/rgbgb_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgb_window: 7x7 sliding window and line store write-back
// Shifts the window one column per pixel, loads the new column from the
// line word in rotated line order and merges the new grey byte into the
// word written back to the line store.
// ----------------------------------------------------------------------------
module rgbgb_window (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2:0]       slot_i,
  input  logic [7:0]       grey_i,
  input  rgbgb_pkg::line_t line_data_i,
  output rgbgb_pkg::line_t wr_data_o,
  output rgbgb_pkg::win_t  win_o
);

  rgbgb_pkg::win_t win_q;
  rgbgb_pkg::win_t win_d;

  always_comb begin
    logic [3:0] sum;
    logic [2:0] sel;
    win_d = win_q;
    for (int y = 0; y < rgbgb_pkg::WIN; y++) begin
      for (int x = 0; x < rgbgb_pkg::WIN_LAST; x++) begin
        win_d[y][x] = win_q[y][x+1];
      end
    end
    // Window row k takes the line that is k rows younger than the oldest.
    for (int k = 0; k < rgbgb_pkg::LINES; k++) begin
      sum = 4'(slot_i) + 4'(k);
      if (sum >= 4'(rgbgb_pkg::LINES)) begin
        sum = sum - 4'(rgbgb_pkg::LINES);
      end
      sel = sum[2:0];
      win_d[k][rgbgb_pkg::WIN_LAST] = line_data_i[sel];
    end
    win_d[rgbgb_pkg::WIN_LAST][rgbgb_pkg::WIN_LAST] = grey_i;
  end

  always_comb begin
    wr_data_o         = line_data_i;
    wr_data_o[slot_i] = grey_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      win_q <= win_d;
    end
  end

  assign win_o = win_q;

endmodule

// ===== sv/rgbgb_kernel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgb_kernel: weighted window sum and scaling pipeline
// Five stages: row sums, window sum, divide by ten, divide by 101.5 and
// saturation. All stages advance together on the pipeline enable.
// ----------------------------------------------------------------------------
module rgbgb_kernel (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  rgbgb_pkg::meta_t      meta_i,
  input  rgbgb_pkg::win_t       win_i,
  output logic                  valid_o,
  output rgbgb_pkg::meta_t      meta_o,
  output logic [7:0]            blurred_o
);

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0]                          vld_q;
  rgbgb_pkg::meta_t                           meta_q [STAGES];
  logic [rgbgb_pkg::WIN-1:0][rgbgb_pkg::ROW_W-1:0] rows_q, rows_d;
  logic [rgbgb_pkg::SUM_W-1:0]                sum_q, sum_d;
  logic [rgbgb_pkg::P10_W-1:0]                p10_q;
  logic [rgbgb_pkg::P203_W-1:0]               p203_q;
  logic [7:0]                                 blur_q, blur_d;
  logic [rgbgb_pkg::Q10_W-1:0]                q10;
  logic [rgbgb_pkg::TWO_M_W-1:0]              two_m;
  logic [rgbgb_pkg::P203_W-rgbgb_pkg::DIV203_SH-1:0] q203;

  always_comb begin
    for (int y = 0; y < rgbgb_pkg::WIN; y++) begin
      rows_d[y] = '0;
      for (int x = 0; x < rgbgb_pkg::WIN; x++) begin
        rows_d[y] = rows_d[y] + rgbgb_pkg::ROW_W'(rgbgb_pkg::WEIGHT[y][x])
                    * rgbgb_pkg::ROW_W'(win_i[y][x]);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int y = 0; y < rgbgb_pkg::WIN; y++) begin
      sum_d = sum_d + rgbgb_pkg::SUM_W'(rows_q[y]);
    end
  end

  assign q10   = p10_q[rgbgb_pkg::DIV10_SH +: rgbgb_pkg::Q10_W];
  assign two_m = {q10, 1'b0};
  assign q203  = p203_q[rgbgb_pkg::P203_W-1:rgbgb_pkg::DIV203_SH];

  always_comb begin
    if (q203 > $bits(q203)'(rgbgb_pkg::BLUR_MAX)) begin
      blur_d = 8'(rgbgb_pkg::BLUR_MAX);
    end else begin
      blur_d = q203[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_i;
      for (int i = 1; i < STAGES; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      rows_q <= rows_d;
      sum_q  <= sum_d;
      p10_q  <= rgbgb_pkg::P10_W'(sum_q) * rgbgb_pkg::P10_W'(rgbgb_pkg::DIV10_MUL);
      p203_q <= rgbgb_pkg::P203_W'(two_m) * rgbgb_pkg::P203_W'(rgbgb_pkg::DIV203_MUL);
      blur_q <= blur_d;
    end
  end

  assign valid_o   = vld_q[STAGES-1];
  assign meta_o    = meta_q[STAGES-1];
  assign blurred_o = blur_q;

endmodule

// ===== sv/rgb_grey_gaussian_blur_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_grey_gaussian_blur_top: streamed RGB to grey with a 7x7 blur kernel
// Converts raster RGB pixels to grey, keeps six grey lines and emits one
// blurred value for every interior pixel of the frame.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one RGB pixel per item in raster order. The
// output stream carries one item per interior centre pixel (row and column
// 3 to size-4): the blurred grey value, its column, its mirrored row, and
// tlast on the last interior pixel of the frame. Border pixels give no item.
// The result for a centre pixel leaves once the pixel three columns right
// and three rows down has been taken in.
// Throughput is one pixel per clock while the skid register is empty. The
// line store is a single word-wide memory (all six lines of one column in
// one word): each pixel reads its column at acceptance and the window stage
// writes it back, so one read and one write port carry the full rate. From
// its completing pixel, a result passes the line word read at acceptance,
// the window, five kernel and scaling stages and the output register.
// Reset clears the counters and the pipeline and loads a 640 x 480 size;
// the line store needs no clearing, since every entry is written before a
// result reads it. Image size is written on the config channel between
// frames. When the receiver stalls, the output register holds its item and
// a skid register catches one more; only with the skid full does s_axis
// drop tready, and that ready comes straight from a register.
// ----------------------------------------------------------------------------
module rgb_grey_gaussian_blur_top #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input; tdata: red [7:0], green [15:8], blue [23:16].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // Blur output; tdata: blurred [7:0], out_column [18:8], out_row [29:19],
  // zero [31:30]. tlast is frame_end.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Configuration writes: index 0 image_width, index 1 image_height.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WLW = ($clog2(MAX_WIDTH + 1) > rgbgb_pkg::CFG_W) ?
                                $clog2(MAX_WIDTH + 1) : rgbgb_pkg::CFG_W;
  localparam int unsigned HLW = ($clog2(MAX_HEIGHT + 1) > rgbgb_pkg::CFG_W) ?
                                $clog2(MAX_HEIGHT + 1) : rgbgb_pkg::CFG_W;
  localparam int unsigned CRW = (CW > RW) ? CW : RW;
  localparam int unsigned XW  = (CRW > rgbgb_pkg::OUT_W) ? CRW : rgbgb_pkg::OUT_W;

  // Configuration registers and the clamped sizes in use.
  logic [rgbgb_pkg::CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic [WLW-1:0]              w_clamp;
  logic [HLW-1:0]              h_clamp;
  logic [CW-1:0]               wm1;
  logic [RW-1:0]               hm1;

  // Position of the next pixel.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [2:0]    slot_q, slot_d;

  // Handshake and pipeline enable.
  logic in_acc;
  logic en;

  // Acceptance stage outputs.
  logic [rgbgb_pkg::GREY_W-1:0] grey_sum;
  logic [7:0]                   grey;
  logic                         has_res;
  rgbgb_pkg::meta_t             meta0;

  // Stage after acceptance: line word being read.
  logic             v1_q;
  logic             res1_q;
  logic [7:0]       grey1_q;
  logic [CW-1:0]    col1_q;
  logic [2:0]       slot1_q;
  rgbgb_pkg::meta_t meta1_q;

  // Stage holding the updated window.
  logic             v2_q;
  logic             res2_q;
  rgbgb_pkg::meta_t meta2_q;

  rgbgb_pkg::line_t line_rd;
  rgbgb_pkg::line_t line_wr;
  rgbgb_pkg::win_t  win;

  logic             kres_valid;
  rgbgb_pkg::meta_t kres_meta;
  logic [7:0]       kres_blur;

  // Output register and skid register.
  logic             out_valid_q, skid_valid_q;
  rgbgb_pkg::meta_t out_meta_q, skid_meta_q;
  logic [7:0]       out_blur_q, skid_blur_q;
  logic             out_ready;

  // ------------------------------------------------------------------------
  // Configuration
  // ------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= rgbgb_pkg::CFG_W'(rgbgb_pkg::WIDTH_RESET);
      cfg_height_q <= rgbgb_pkg::CFG_W'(rgbgb_pkg::HEIGHT_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rgbgb_pkg::cfg_reg_e'(cfg_index_i))
        rgbgb_pkg::REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i;
        rgbgb_pkg::REG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes are clamped to 7 .. MAX; counters compare against size minus one.
  always_comb begin
    if (cfg_width_q < rgbgb_pkg::CFG_W'(rgbgb_pkg::MIN_SIZE)) begin
      w_clamp = WLW'(rgbgb_pkg::MIN_SIZE);
    end else if (WLW'(cfg_width_q) > WLW'(MAX_WIDTH)) begin
      w_clamp = WLW'(MAX_WIDTH);
    end else begin
      w_clamp = WLW'(cfg_width_q);
    end
    if (cfg_height_q < rgbgb_pkg::CFG_W'(rgbgb_pkg::MIN_SIZE)) begin
      h_clamp = HLW'(rgbgb_pkg::MIN_SIZE);
    end else if (HLW'(cfg_height_q) > HLW'(MAX_HEIGHT)) begin
      h_clamp = HLW'(MAX_HEIGHT);
    end else begin
      h_clamp = HLW'(cfg_height_q);
    end
  end

  assign wm1 = CW'(w_clamp - WLW'(1));
  assign hm1 = RW'(h_clamp - HLW'(1));

  // ------------------------------------------------------------------------
  // Acceptance: grey conversion, position counters, result decision
  // ------------------------------------------------------------------------
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign grey_sum = rgbgb_pkg::GREY_W'(rgbgb_pkg::GREY_R) * rgbgb_pkg::GREY_W'(s_axis_tdata[7:0])
                  + rgbgb_pkg::GREY_W'(rgbgb_pkg::GREY_G) * rgbgb_pkg::GREY_W'(s_axis_tdata[15:8])
                  + rgbgb_pkg::GREY_W'(rgbgb_pkg::GREY_B) * rgbgb_pkg::GREY_W'(s_axis_tdata[23:16]);
  assign grey     = grey_sum[rgbgb_pkg::GREY_SH +: 8];

  // A result needs six full lines above and six pixels to the left, and a
  // position that lies inside the current frame size.
  assign has_res = (col_q >= CW'(rgbgb_pkg::WIN_LAST)) && (row_q >= RW'(rgbgb_pkg::WIN_LAST))
                && (col_q <= wm1) && (row_q <= hm1);

  assign meta0.out_column = rgbgb_pkg::OUT_W'(XW'(col_q) - XW'(rgbgb_pkg::BORDER));
  assign meta0.out_row    = rgbgb_pkg::OUT_W'(XW'(hm1) - XW'(row_q) + XW'(rgbgb_pkg::BORDER));
  assign meta0.frame_end  = (col_q == wm1) && (row_q == hm1);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (in_acc) begin
      if (col_q >= wm1) begin
        col_d = '0;
        if (row_q >= hm1) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + RW'(1);
          slot_d = (slot_q == 3'(rgbgb_pkg::LINES - 1)) ? 3'd0 : slot_q + 3'd1;
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // ------------------------------------------------------------------------
  // Pipeline registers ahead of the kernel
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_acc;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res1_q  <= has_res;
      grey1_q <= grey;
      col1_q  <= col_q;
      slot1_q <= slot_q;
      meta1_q <= meta0;
      res2_q  <= res1_q;
      meta2_q <= meta1_q;
    end
  end

  // The line word is read when the pixel is accepted and written back by
  // the window stage as the window takes in that pixel. Two successive pixels never
  // share a column, so the write never races a read of the same word.
  rgbgb_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (en && v1_q),
    .wr_addr_i (col1_q),
    .wr_data_i (line_wr)
  );

  rgbgb_window u_window (
    .clk_i       (clk_i),
    .en_i        (en),
    .valid_i     (v1_q),
    .slot_i      (slot1_q),
    .grey_i      (grey1_q),
    .line_data_i (line_rd),
    .wr_data_o   (line_wr),
    .win_o       (win)
  );

  rgbgb_kernel u_kernel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v2_q && res2_q),
    .meta_i    (meta2_q),
    .win_i     (win),
    .valid_o   (kres_valid),
    .meta_o    (kres_meta),
    .blurred_o (kres_blur)
  );

  // ------------------------------------------------------------------------
  // Output register with skid register
  // ------------------------------------------------------------------------
  assign out_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= kres_valid;
      end
    end else if (en && kres_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_meta_q <= skid_meta_q;
        out_blur_q <= skid_blur_q;
      end else begin
        out_meta_q <= kres_meta;
        out_blur_q <= kres_blur;
      end
    end else if (en && kres_valid) begin
      skid_meta_q <= kres_meta;
      skid_blur_q <= kres_blur;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_meta_q.out_row, out_meta_q.out_column, out_blur_q};
  assign m_axis_tlast  = out_meta_q.frame_end;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  // The skid register only fills behind a waiting output item.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the output register is empty");

  // The write-back and a new read never address the same line word.
  a_no_word_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && v1_q) |-> (col_q != col1_q))
    else $error("line store read and write-back hit the same column");

  // The line slot stays within the six lines of the line store word.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q < 3'(rgbgb_pkg::LINES)) && (slot1_q < 3'(rgbgb_pkg::LINES) || !v1_q))
    else $error("line slot out of range");

  // A result leaves the kernel only into a free output or skid register.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kres_valid && en && !out_ready) |=> skid_valid_q)
    else $error("kernel result was not captured");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rgb_grey_gaussian_blur_top
// Streams RGB frames of several sizes into the block and keeps a cycle-free
// prediction of every blurred item: the grey conversion, six line stores and
// the sliding 7x7 window. Results are checked in order, field by field.
// Frames run with and without idle cycles on either side and through one
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_PIX       = 2048;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // Kernel weights in tenths, centre at [3][3].
  localparam int unsigned KERNEL_TENTHS [7][7] = '{
    '{0,  0,   0,   5,   0,  0, 0},
    '{0,  5,  18,  32,  18,  5, 0},
    '{0, 18,  64, 100,  64, 18, 0},
    '{5, 32, 100, 100, 100, 32, 5},
    '{0, 18,  64, 100,  64, 18, 0},
    '{0,  5,  18,  32,  18,  5, 0},
    '{0,  0,   0,   5,   0,  0, 0}
  };

  typedef enum int unsigned {
    PIX_RANDOM,
    PIX_BRIGHT,
    PIX_EXTREME,
    PIX_WHITE,
    PIX_BLACK
  } pix_mode_e;

  typedef struct packed {
    logic                        frame_end;
    logic [rgbgb_pkg::OUT_W-1:0] row;
    logic [rgbgb_pkg::OUT_W-1:0] column;
    logic [7:0]                  value;
  } blur_item_t;

  // Block ports. Every input is known from time zero.
  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [23:0]                 s_axis_tdata  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [31:0]                 m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [0:0]                  cfg_index_i   = '0;
  logic [rgbgb_pkg::CFG_W-1:0] cfg_data_i    = '0;

  // Stimulus and checking state.
  logic [23:0]       pixel_q [$];
  blur_item_t        blur_q [$];
  int unsigned       pixels_in_flight = 0;
  int unsigned       send_idle_pct    = 0;
  int unsigned       recv_stall_pct   = 0;
  int unsigned       error_count      = 0;
  int unsigned       cycle_count      = 0;
  logic              hold_arm         = 1'b0;
  logic              hold_off         = 1'b0;

  // Shadow of the block: line stores, window, raster position and size.
  logic [7:0]                  grey_store [6][MAX_PIX];
  logic [7:0]                  pix_window [7][7];
  int unsigned                 next_col;
  int unsigned                 next_row;
  logic [rgbgb_pkg::CFG_W-1:0] cfg_width;
  logic [rgbgb_pkg::CFG_W-1:0] cfg_height;

  rgb_grey_gaussian_blur_top #(
    .MAX_WIDTH  (MAX_PIX),
    .MAX_HEIGHT (MAX_PIX)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Out-of-range sizes are clamped to 7..MAX_PIX.
  function automatic int unsigned size_in_use(input logic [rgbgb_pkg::CFG_W-1:0] v);
    if (v < rgbgb_pkg::MIN_SIZE) return rgbgb_pkg::MIN_SIZE;
    if (v > MAX_PIX) return MAX_PIX;
    return v;
  endfunction

  // Takes in one pixel and queues the blurred item it completes, if any.
  function automatic void blur_predict(input logic [23:0] px);
    int unsigned w, h, c, r, cs, grey, acc, x, y;
    blur_item_t  res;
    w  = size_in_use(cfg_width);
    h  = size_in_use(cfg_height);
    c  = next_col;
    r  = next_row;
    cs = (c < MAX_PIX) ? c : MAX_PIX - 1;
    grey = (307 * px[7:0] + 604 * px[15:8] + 113 * px[23:16]) >> 10;

    // Shift the window left; the new column holds rows r-6..r-1, then r.
    for (y = 0; y < 7; y++)
      for (x = 0; x < 6; x++)
        pix_window[y][x] = pix_window[y][x+1];
    for (y = 0; y < 6; y++)
      pix_window[y][6] = grey_store[(r + y) % 6][cs];
    pix_window[6][6] = grey[7:0];
    grey_store[r % 6][cs] = grey[7:0];

    if (c >= 6 && r >= 6 && c < w && r < h) begin
      acc = 0;
      for (y = 0; y < 7; y++)
        for (x = 0; x < 7; x++)
          acc += KERNEL_TENTHS[y][x] * pix_window[y][x];
      acc = (2 * (acc / 10)) / 203;
      res.value     = (acc > 255) ? 8'd255 : acc[7:0];
      res.column    = rgbgb_pkg::OUT_W'(c - 3);
      res.row       = rgbgb_pkg::OUT_W'(h - 1 - (r - 3));
      res.frame_end = (c == w - 1) && (r == h - 1);
      blur_q.push_back(res);
    end

    if (c >= w - 1) begin
      next_col = 0;
      next_row = (r >= h - 1) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  task automatic flag_error(input string what, input int unsigned got,
                            input int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
             what, got, want, cycle_count);
    error_count++;
  endtask

  // Register writes happen only with the block idle, so the shadow size is
  // updated right at the handshake.
  task automatic write_reg(input rgbgb_pkg::cfg_reg_e idx,
                           input logic [rgbgb_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == rgbgb_pkg::REG_IMAGE_WIDTH) cfg_width = val;
    else cfg_height = val;
  endtask

  // Waits until every pixel is taken and every blurred item has come out,
  // then lets the pipeline run empty.
  task automatic drain();
    @(posedge clk_i);
    while (pixels_in_flight != 0 || blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Queues one whole frame at the current size.
  task automatic push_frame(input pix_mode_e mode);
    int unsigned n;
    logic [23:0] px;
    n = size_in_use(cfg_width) * size_in_use(cfg_height);
    repeat (n) begin
      case (mode)
        PIX_WHITE: px = '1;
        PIX_BLACK: px = '0;
        PIX_EXTREME: begin
          px = {($urandom_range(1, 0) != 0) ? 8'hFF : 8'h00,
                ($urandom_range(1, 0) != 0) ? 8'hFF : 8'h00,
                ($urandom_range(1, 0) != 0) ? 8'hFF : 8'h00};
        end
        // Bright frames sit around the level where the blur saturates.
        PIX_BRIGHT: begin
          px = {8'($urandom_range(255, 235)), 8'($urandom_range(255, 235)),
                8'($urandom_range(255, 235))};
        end
        default: px = 24'($urandom);
      endcase
      pixel_q.push_back(px);
      pixels_in_flight++;
    end
  endtask

  // Random frames, mostly small, with new sizes now and then. A low
  // register value is sometimes written to exercise the clamp.
  task automatic random_phase(input int unsigned idle, input int unsigned stall,
                              input int unsigned quota);
    int unsigned sent, pick;
    logic [rgbgb_pkg::CFG_W-1:0] w, h;
    pix_mode_e mode;
    sent = 0;
    send_idle_pct  <= idle;
    recv_stall_pct <= stall;
    while (sent < quota) begin
      if ($urandom_range(2, 0) == 0) begin
        drain();
        w = ($urandom_range(9, 0) == 0) ? rgbgb_pkg::CFG_W'($urandom_range(6, 0))
                                        : rgbgb_pkg::CFG_W'($urandom_range(16, 7));
        h = ($urandom_range(9, 0) == 0) ? rgbgb_pkg::CFG_W'($urandom_range(6, 0))
                                        : rgbgb_pkg::CFG_W'($urandom_range(10, 7));
        pick = $urandom_range(2, 0);
        if (pick != 1) write_reg(rgbgb_pkg::REG_IMAGE_WIDTH, w);
        if (pick != 0) write_reg(rgbgb_pkg::REG_IMAGE_HEIGHT, h);
      end
      case ($urandom_range(9, 0))
        6, 7:    mode = PIX_BRIGHT;
        8:       mode = PIX_EXTREME;
        9:       mode = ($urandom_range(1, 0) != 0) ? PIX_WHITE : PIX_BLACK;
        default: mode = PIX_RANDOM;
      endcase
      push_frame(mode);
      sent += size_in_use(cfg_width) * size_in_use(cfg_height);
    end
  endtask

  // Pixel sender: offers the next queued pixel unless it idles this cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        s_axis_tdata  <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted pixel advances the shadow model.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      blur_predict(s_axis_tdata);
      pixels_in_flight--;
    end
  end

  // Receiver: random stalls, plus the long hold-off when it is active.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // The long hold-off is timed here while the sender keeps offering pixels,
  // so the output register and skid fill and the input has to stall.
  initial begin : long_hold
    wait (hold_arm);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Each output item is matched against the oldest prediction.
  always @(posedge clk_i) begin : blur_check
    blur_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blur_q.size() == 0) begin
        flag_error("item with nothing pending", m_axis_tdata, 0);
      end else begin
        want = blur_q.pop_front();
        if (m_axis_tdata[7:0] != want.value)
          flag_error("blurred", m_axis_tdata[7:0], want.value);
        if (m_axis_tdata[18:8] != want.column)
          flag_error("out_column", m_axis_tdata[18:8], want.column);
        if (m_axis_tdata[29:19] != want.row)
          flag_error("out_row", m_axis_tdata[29:19], want.row);
        if (m_axis_tdata[31:30] != 2'b00)
          flag_error("tdata padding", m_axis_tdata[31:30], 0);
        if (m_axis_tlast != want.frame_end)
          flag_error("frame_end", m_axis_tlast, want.frame_end);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL rgb_grey_gaussian_blur_top");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned y, x;
    for (y = 0; y < 6; y++)
      for (x = 0; x < MAX_PIX; x++)
        grey_store[y][x] = '0;
    for (y = 0; y < 7; y++)
      for (x = 0; x < 7; x++)
        pix_window[y][x] = '0;
    next_col   = 0;
    next_row   = 0;
    cfg_width  = rgbgb_pkg::CFG_W'(rgbgb_pkg::WIDTH_RESET);
    cfg_height = rgbgb_pkg::CFG_W'(rgbgb_pkg::HEIGHT_RESET);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Smallest frames (one interior pixel each), then 9 x 8 frames. White saturates the blur.
    write_reg(rgbgb_pkg::REG_IMAGE_WIDTH, 7);
    write_reg(rgbgb_pkg::REG_IMAGE_HEIGHT, 7);
    push_frame(PIX_WHITE);
    push_frame(PIX_BLACK);
    push_frame(PIX_EXTREME);
    drain();
    write_reg(rgbgb_pkg::REG_IMAGE_WIDTH, 9);
    write_reg(rgbgb_pkg::REG_IMAGE_HEIGHT, 8);
    push_frame(PIX_BRIGHT);
    push_frame(PIX_EXTREME);
    drain();

    // Back-to-back frames under the long receiver hold-off.
    write_reg(rgbgb_pkg::REG_IMAGE_WIDTH, 16);
    write_reg(rgbgb_pkg::REG_IMAGE_HEIGHT, 12);
    hold_arm = 1'b1;
    push_frame(PIX_RANDOM);
    push_frame(PIX_RANDOM);
    drain();

    // Register values below the smallest size are clamped up.
    write_reg(rgbgb_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(rgbgb_pkg::REG_IMAGE_HEIGHT, 3);
    push_frame(PIX_RANDOM);
    drain();

    // Random frames: no idling, idle sender, stalling receiver, then both.
    random_phase(0, 0, 80);
    random_phase(67, 0, 80);
    random_phase(0, 67, 80);
    random_phase(35, 35, 80);
    drain();

    if (error_count == 0) begin
      $display("PASS rgb_grey_gaussian_blur_top");
    end else begin
      $display("FAIL rgb_grey_gaussian_blur_top");
    end
    $finish;
  end

endmodule
